/* hw/rtl/boosted_tree_split_finder_macros.svh */
// ----------------------------------------------------------------------------
// boosted_tree_split_finder_macros: assertion macros
// shared shorthand for the concurrent checks of the split finder
// ----------------------------------------------------------------------------
`ifndef BOOSTED_TREE_SPLIT_FINDER_MACROS_SVH
`define BOOSTED_TREE_SPLIT_FINDER_MACROS_SVH

// same-cycle implication, disabled in reset
`define BTSF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define BTSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/btsf_pkg.sv */
// ----------------------------------------------------------------------------
// btsf_pkg: split finder package
// widths, defaults, register indexes and state types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package btsf_pkg;

   localparam int GRAD_W       = 24;
   localparam int HESS_W       = 24;
   localparam int FEAT_W       = 32;
   localparam int GAIN_W       = 48;
   localparam int LAMBDA_W     = 24;
   localparam int MASK_W       = 8;
   localparam int FEAT_IDX_W   = 3;
   localparam int FEAT_CNT_W   = 4;
   localparam int CSR_DATA_W   = 24;
   localparam int CSR_INDEX_W  = 1;
   localparam int NUM_FEAT_PORTS = 8;

   localparam int DEF_MAX_INSTANCES = 1024;
   localparam int DEF_FEATURE_COUNT = 8;

   localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 24'd65536;
   localparam logic [MASK_W-1:0]   MASK_RESET   = 8'hFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LAMBDA = 1'b0,
      CSR_MASK   = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INIT,
      ST_GAMMA,
      ST_GAMMA_WAIT,
      ST_FEAT,
      ST_KEY,
      ST_KEY_WAIT,
      ST_RANK,
      ST_ORD,
      ST_ORD_WAIT,
      ST_DATA,
      ST_TERM_L,
      ST_TERM_L_WAIT,
      ST_TERM_R,
      ST_TERM_R_WAIT,
      ST_EVAL,
      ST_DONE
   } btsf_state_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_MUL,
      T_DIV,
      T_DONE
   } term_state_type;

endpackage

/* hw/rtl/btsf_ram.sv */
// ----------------------------------------------------------------------------
// btsf_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module btsf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/btsf_term.sv */
// ----------------------------------------------------------------------------
// btsf_term: shared score term unit
// computes mag^2 / den with a shift-add multiply then a restoring divide
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module btsf_term #(
   parameter int SW = 35,
   parameter int DW = 36
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [SW-1:0]   mag,
   input  logic [DW-1:0]   den,
   output logic            done,
   output logic [2*SW-1:0] quot
);
   import btsf_pkg::*;

   localparam int QW   = 2 * SW;
   localparam int CNTW = $clog2(QW + 1);

   term_state_type state_ff, state_in;
   logic [QW-1:0]   mcand_ff, mcand_in;
   logic [SW-1:0]   mplier_ff, mplier_in;
   logic [QW-1:0]   prod_ff, prod_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   den_ff, den_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [DW:0]     shifted;
   logic            fits;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: if (start) state_in = T_MUL;
         T_MUL:  if (cnt_ff == CNTW'(1)) state_in = T_DIV;
         T_DIV:  if (cnt_ff == CNTW'(1)) state_in = T_DONE;
         T_DONE: state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done = (state_ff == T_DONE);
      quot = prod_ff;
   end

   assign shifted = {rem_ff, prod_ff[QW-1]};
   assign fits    = (shifted >= {1'b0, den_ff});

   // datapath
   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (start) begin
               mcand_in  = QW'(mag);
               mplier_in = mag;
               prod_in   = '0;
               rem_in    = '0;
               den_in    = den;
               cnt_in    = CNTW'(SW);
            end
         end
         T_MUL: begin
            if (mplier_ff[0]) prod_in = prod_ff + mcand_ff;
            mcand_in  = {mcand_ff[QW-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[SW-1:1]};
            cnt_in    = (cnt_ff == CNTW'(1)) ? CNTW'(QW) : cnt_ff - 1'b1;
         end
         T_DIV: begin
            rem_in  = fits ? DW'(shifted - {1'b0, den_ff}) : shifted[DW-1:0];
            prod_in = {prod_ff[QW-2:0], fits};
            cnt_in  = cnt_ff - 1'b1;
         end
         T_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      cnt_ff    <= cnt_in;
   end

endmodule

/* hw/rtl/boosted_tree_split_finder.sv */
// loading: one item per cycle while busy is low; a node's last item starts the search that
//   ends in the result strobe, its length set by the ranking loop over the instance ram and
//   the shared serial multiply/divide term unit
// throughput: one node at a time; busy stays high until the result strobe
// reset: clears sequencer, counts and totals; rams are not cleared; the receiver cannot stall
// ----------------------------------------------------------------------------
// boosted_tree_split_finder: exact greedy split search
// loads a node's instances, ranks each enabled feature stably, scans prefix
// sums and keeps the best gain, feature and threshold
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module boosted_tree_split_finder #(
   parameter int MAX_INSTANCES = btsf_pkg::DEF_MAX_INSTANCES,
   parameter int FEATURE_COUNT = btsf_pkg::DEF_FEATURE_COUNT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [btsf_pkg::GRAD_W-1:0]   req_grad_value,
   input  logic [btsf_pkg::HESS_W-1:0]          req_hess_value,
   input  logic signed [btsf_pkg::FEAT_W-1:0]   req_feat_0,
   input  logic signed [btsf_pkg::FEAT_W-1:0]   req_feat_1,
   input  logic signed [btsf_pkg::FEAT_W-1:0]   req_feat_2,
   input  logic signed [btsf_pkg::FEAT_W-1:0]   req_feat_3,
   input  logic signed [btsf_pkg::FEAT_W-1:0]   req_feat_4,
   input  logic signed [btsf_pkg::FEAT_W-1:0]   req_feat_5,
   input  logic signed [btsf_pkg::FEAT_W-1:0]   req_feat_6,
   input  logic signed [btsf_pkg::FEAT_W-1:0]   req_feat_7,
   input  logic                                 req_last_instance,
   output logic                                 rsp_valid,
   output logic                                 rsp_split_found,
   output logic [btsf_pkg::FEAT_IDX_W-1:0]      rsp_win_feature,
   output logic signed [btsf_pkg::FEAT_W-1:0]   rsp_win_threshold,
   output logic [btsf_pkg::GAIN_W-1:0]          rsp_best_gain,
   input  logic                                 csr_wr_en,
   input  logic [btsf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [btsf_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import btsf_pkg::*;

   localparam int AW = $clog2(MAX_INSTANCES);
   localparam int CW = AW + 1;
   localparam int SW = GRAD_W + AW + 1;          // signed sum width
   localparam int DW = SW + 1;                   // divisor width
   localparam int QW = 2 * SW;                   // term width
   localparam int IW = GRAD_W + HESS_W + FEAT_W * FEATURE_COUNT;
   localparam int FB = GRAD_W + HESS_W;          // first feature bit in a ram word
   localparam logic [MASK_W-1:0] MASK_VALID = MASK_W'((1 << FEATURE_COUNT) - 1);

   btsf_state_type state_ff, state_in;

   logic [CW-1:0]           count_ff, count_in;
   logic signed [SW-1:0]    gtot_ff, gtot_in;
   logic [SW-1:0]           htot_ff, htot_in;
   logic [LAMBDA_W-1:0]     lam_ff, lam_in;
   logic [MASK_W-1:0]       mask_ff, mask_in;
   logic [FEAT_CNT_W-1:0]   f_ff, f_in;
   logic [CW-1:0]           i_ff, i_in;
   logic [CW-1:0]           jc_ff, jc_in;
   logic [AW-1:0]           rank_ff, rank_in;
   logic signed [FEAT_W-1:0] key_ff, key_in;
   logic [CW-1:0]           p_ff, p_in;
   logic signed [SW-1:0]    gl_ff, gl_in;
   logic [SW-1:0]           hl_ff, hl_in;
   logic signed [FEAT_W-1:0] thr_ff, thr_in;
   logic [QW-1:0]           gamma_ff, gamma_in;
   logic [QW-1:0]           tl_ff, tl_in;
   logic                    found_ff, found_in;
   logic [FEAT_IDX_W-1:0]   bfeat_ff, bfeat_in;
   logic signed [FEAT_W-1:0] bthr_ff, bthr_in;
   logic [GAIN_W-1:0]       bgain_ff, bgain_in;

   logic                    accept;
   logic                    store_ok;
   logic [CW-1:0]           n_last;
   logic [MASK_W-1:0]       mask_eff;
   logic [LAMBDA_W-1:0]     lam_eff;

   // instance ram: {features, hessian, gradient}
   logic                    inst_we;
   logic [AW-1:0]           inst_raddr;
   logic [IW-1:0]           inst_wdata, inst_rdata;
   // sorted order ram
   logic                    ord_we;
   logic [AW-1:0]           ord_waddr, ord_rdata;

   logic signed [FEAT_W-1:0] feat_ports [NUM_FEAT_PORTS];
   logic signed [FEAT_W-1:0] rd_key;
   logic signed [SW-1:0]    rd_grad;
   logic [SW-1:0]           rd_hess;
   logic                    lt;

   // term unit
   logic                    term_go, term_done;
   logic signed [SW-1:0]    g_sel;
   logic [SW-1:0]           h_sel;
   logic [SW-1:0]           term_mag;
   logic [DW-1:0]           term_den;
   logic [QW-1:0]           term_quot;

   logic [QW:0]             score, score_diff;
   logic [GAIN_W-1:0]       gain;

   assign accept   = start && !busy;
   assign store_ok = (count_ff < CW'(MAX_INSTANCES));
   assign n_last   = count_ff - 1'b1;
   // empty mask falls back to feature 0 alone
   assign mask_eff = ((mask_ff & MASK_VALID) == '0) ? MASK_W'(1) : (mask_ff & MASK_VALID);
   // zero lambda acts as one lsb
   assign lam_eff  = (lam_ff == '0) ? LAMBDA_W'(1) : lam_ff;

   assign feat_ports[0] = req_feat_0;
   assign feat_ports[1] = req_feat_1;
   assign feat_ports[2] = req_feat_2;
   assign feat_ports[3] = req_feat_3;
   assign feat_ports[4] = req_feat_4;
   assign feat_ports[5] = req_feat_5;
   assign feat_ports[6] = req_feat_6;
   assign feat_ports[7] = req_feat_7;

   always_comb begin
      inst_wdata = '0;
      inst_wdata[GRAD_W-1:0]  = req_grad_value;
      inst_wdata[FB-1:GRAD_W] = req_hess_value;
      for (int k = 0; k < FEATURE_COUNT; k++) begin
         inst_wdata[FB + FEAT_W*k +: FEAT_W] = feat_ports[k];
      end
   end

   // fields of the word on the ram read port
   assign rd_grad = SW'(signed'(inst_rdata[GRAD_W-1:0]));
   assign rd_hess = SW'(inst_rdata[FB-1:GRAD_W]);
   assign rd_key  = inst_rdata[FB + FEAT_W*f_ff[FEAT_IDX_W-1:0] +: FEAT_W];

   // stable rank: earlier instances with an equal key go first
   assign lt = (rd_key < key_ff) || ((rd_key == key_ff) && (jc_ff < i_ff));

   assign inst_we = accept && store_ok;

   always_comb begin
      unique case (state_ff)
         ST_KEY:      inst_raddr = i_ff[AW-1:0];
         ST_KEY_WAIT: inst_raddr = '0;
         ST_RANK:     inst_raddr = AW'(jc_ff + 1'b1);
         ST_ORD_WAIT: inst_raddr = ord_rdata;
         default:     inst_raddr = count_ff[AW-1:0];
      endcase
   end

   assign ord_we    = (state_ff == ST_RANK) && (jc_ff == n_last);
   assign ord_waddr = AW'(rank_ff + AW'(lt));

   btsf_ram #(.WIDTH(IW), .DEPTH(MAX_INSTANCES)) u_inst_ram (
      .clock   (clock),
      .wr_en   (inst_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (inst_wdata),
      .rd_addr (inst_raddr),
      .rd_data (inst_rdata)
   );

   btsf_ram #(.WIDTH(AW), .DEPTH(MAX_INSTANCES)) u_ord_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_waddr),
      .wr_data (i_ff[AW-1:0]),
      .rd_addr (p_ff[AW-1:0]),
      .rd_data (ord_rdata)
   );

   // operand select for the shared term unit
   always_comb begin
      unique case (state_ff)
         ST_TERM_L: begin
            g_sel = gl_ff;
            h_sel = hl_ff;
         end
         ST_TERM_R: begin
            g_sel = gtot_ff - gl_ff;
            h_sel = htot_ff - hl_ff;
         end
         default: begin
            g_sel = gtot_ff;
            h_sel = htot_ff;
         end
      endcase
   end

   assign term_mag = g_sel[SW-1] ? SW'(-g_sel) : SW'(g_sel);
   assign term_den = {1'b0, h_sel} + DW'(lam_eff);
   assign term_go  = (state_ff == ST_GAMMA) || (state_ff == ST_TERM_L) ||
                     (state_ff == ST_TERM_R);

   btsf_term #(.SW(SW), .DW(DW)) u_term (
      .clock (clock),
      .reset (reset),
      .start (term_go),
      .mag   (term_mag),
      .den   (term_den),
      .done  (term_done),
      .quot  (term_quot)
   );

   // split score: left term plus right term minus parent term, saturated
   assign score      = {1'b0, tl_ff} + {1'b0, term_quot};
   assign score_diff = score - {1'b0, gamma_ff};
   always_comb begin
      if (score <= {1'b0, gamma_ff}) begin
         gain = '0;
      end else if (score_diff[QW:GAIN_W] != '0) begin
         gain = '1;
      end else begin
         gain = score_diff[GAIN_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:        if (accept && req_last_instance) state_in = ST_INIT;
         ST_INIT:        state_in = (count_ff < CW'(2)) ? ST_DONE : ST_GAMMA;
         ST_GAMMA:       state_in = ST_GAMMA_WAIT;
         ST_GAMMA_WAIT:  if (term_done) state_in = ST_FEAT;
         ST_FEAT: begin
            if (f_ff == FEAT_CNT_W'(FEATURE_COUNT)) state_in = ST_DONE;
            else if (mask_eff[f_ff[FEAT_IDX_W-1:0]]) state_in = ST_KEY;
         end
         ST_KEY:         state_in = ST_KEY_WAIT;
         ST_KEY_WAIT:    state_in = ST_RANK;
         ST_RANK: begin
            if (jc_ff == n_last) state_in = (i_ff == n_last) ? ST_ORD : ST_KEY;
         end
         ST_ORD:         state_in = ST_ORD_WAIT;
         ST_ORD_WAIT:    state_in = ST_DATA;
         ST_DATA:        state_in = ST_TERM_L;
         ST_TERM_L:      state_in = ST_TERM_L_WAIT;
         ST_TERM_L_WAIT: if (term_done) state_in = ST_TERM_R;
         ST_TERM_R:      state_in = ST_TERM_R_WAIT;
         ST_TERM_R_WAIT: if (term_done) state_in = ST_EVAL;
         ST_EVAL:        state_in = (p_ff == CW'(n_last - 1'b1)) ? ST_FEAT : ST_ORD;
         ST_DONE:        state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy              = (state_ff != ST_IDLE);
      rsp_valid         = (state_ff == ST_DONE);
      rsp_split_found   = found_ff;
      rsp_win_feature   = bfeat_ff;
      rsp_win_threshold = bthr_ff;
      rsp_best_gain     = bgain_ff;
   end

   // datapath
   always_comb begin
      count_in = count_ff;
      gtot_in  = gtot_ff;
      htot_in  = htot_ff;
      lam_in   = lam_ff;
      mask_in  = mask_ff;
      f_in     = f_ff;
      i_in     = i_ff;
      jc_in    = jc_ff;
      rank_in  = rank_ff;
      key_in   = key_ff;
      p_in     = p_ff;
      gl_in    = gl_ff;
      hl_in    = hl_ff;
      thr_in   = thr_ff;
      gamma_in = gamma_ff;
      tl_in    = tl_ff;
      found_in = found_ff;
      bfeat_in = bfeat_ff;
      bthr_in  = bthr_ff;
      bgain_in = bgain_ff;

      // configuration writes must only come while idle; the block itself does not enforce it
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_LAMBDA: lam_in  = csr_wdata[LAMBDA_W-1:0];
            CSR_MASK:   mask_in = csr_wdata[MASK_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            // items past the node capacity are dropped, also from the totals
            if (inst_we) begin
               count_in = count_ff + 1'b1;
               gtot_in  = gtot_ff + SW'(req_grad_value);
               htot_in  = htot_ff + SW'(req_hess_value);
            end
         end
         ST_INIT: begin
            found_in = 1'b0;
            bfeat_in = '0;
            bthr_in  = '0;
            bgain_in = '0;
            f_in     = '0;
         end
         ST_GAMMA_WAIT: if (term_done) gamma_in = term_quot;
         ST_FEAT: begin
            if (f_ff != FEAT_CNT_W'(FEATURE_COUNT)) begin
               if (mask_eff[f_ff[FEAT_IDX_W-1:0]]) i_in = '0;
               else f_in = f_ff + 1'b1;
            end
         end
         ST_KEY_WAIT: begin
            key_in  = rd_key;
            jc_in   = '0;
            rank_in = '0;
         end
         ST_RANK: begin
            rank_in = AW'(rank_ff + AW'(lt));
            jc_in   = jc_ff + 1'b1;
            if (jc_ff == n_last) begin
               i_in  = i_ff + 1'b1;
               p_in  = '0;
               gl_in = '0;
               hl_in = '0;
            end
         end
         ST_DATA: begin
            gl_in  = gl_ff + rd_grad;
            hl_in  = hl_ff + rd_hess;
            thr_in = rd_key;
         end
         ST_TERM_L_WAIT: if (term_done) tl_in = term_quot;
         ST_EVAL: begin
            // strictly greater only: ties keep the earlier split
            if (gain > bgain_ff) begin
               bgain_in = gain;
               bfeat_in = f_ff[FEAT_IDX_W-1:0];
               bthr_in  = thr_ff;
               found_in = 1'b1;
            end
            if (p_ff == CW'(n_last - 1'b1)) f_in = f_ff + 1'b1;
            else p_in = p_ff + 1'b1;
         end
         ST_DONE: begin
            count_in = '0;
            gtot_in  = '0;
            htot_in  = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         gtot_ff  <= '0;
         htot_ff  <= '0;
         lam_ff   <= LAMBDA_RESET;
         mask_ff  <= MASK_RESET;
         found_ff <= 1'b0;
         bfeat_ff <= '0;
         bthr_ff  <= '0;
         bgain_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         gtot_ff  <= gtot_in;
         htot_ff  <= htot_in;
         lam_ff   <= lam_in;
         mask_ff  <= mask_in;
         found_ff <= found_in;
         bfeat_ff <= bfeat_in;
         bthr_ff  <= bthr_in;
         bgain_ff <= bgain_in;
      end
      f_ff     <= f_in;
      i_ff     <= i_in;
      jc_ff    <= jc_in;
      rank_ff  <= rank_in;
      key_ff   <= key_in;
      p_ff     <= p_in;
      gl_ff    <= gl_in;
      hl_ff    <= hl_in;
      thr_ff   <= thr_in;
      gamma_ff <= gamma_in;
      tl_ff    <= tl_in;
   end

endmodule

/* hw/rtl/btsf_checker.sv */
// ----------------------------------------------------------------------------
// btsf_checker: port-level checks for the split finder
// result strobe and busy behavior seen at the top level ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "boosted_tree_split_finder_macros.svh"
module btsf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                req_last_instance,
   input logic                                rsp_valid,
   input logic                                rsp_split_found,
   input logic [btsf_pkg::FEAT_IDX_W-1:0]     rsp_win_feature,
   input logic signed [btsf_pkg::FEAT_W-1:0]  rsp_win_threshold,
   input logic [btsf_pkg::GAIN_W-1:0]         rsp_best_gain
);
   import btsf_pkg::*;

   `BTSF_ASSERT_NEXT(a_last_goes_busy, clock, reset, start && !busy && req_last_instance, busy, "last item did not start a search")
   `BTSF_ASSERT_NEXT(a_plain_load_idle, clock, reset, start && !busy && !req_last_instance, !busy, "plain item left the block busy")
   `BTSF_ASSERT_NEXT(a_single_result, clock, reset, rsp_valid, !rsp_valid && !busy, "result strobe longer than one cycle")
   `BTSF_ASSERT_NOW(a_no_split_zero, clock, reset, rsp_valid && !rsp_split_found, rsp_best_gain == '0 && rsp_win_feature == '0 && rsp_win_threshold == '0, "empty result carries data")
   `BTSF_ASSERT_NOW(a_split_gain, clock, reset, rsp_valid && rsp_split_found, rsp_best_gain != '0, "split found with zero gain")

endmodule

bind boosted_tree_split_finder btsf_checker u_btsf_checker (.*);
